FILE: hw/rtl/bad_pkg.sv
// Shared types and constants for the box-average downscaler.
// No dependencies; used by the queue, front end, back end and top level.
package bad_pkg;

   localparam int CH_W        = 8;
   localparam int NUM_CH      = 4;
   localparam int PIX_W       = CH_W * NUM_CH;
   localparam int COORD_W     = 8;
   localparam int RSP_DATA_W  = PIX_W + 2 * COORD_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int CFG_SIDE_W  = 13;
   localparam int CFG_MAX_W   = 9;
   localparam int QUO_W       = 8;
   localparam int QUO_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CFG_SIDE_W-1:0] RST_SOURCE_SIDE = 13'd1;
   localparam logic [CFG_MAX_W-1:0]  RST_MAX_SIDE    = 9'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH  = 2'd0,
      CSR_SOURCE_HEIGHT = 2'd1,
      CSR_MAX_SIDE      = 2'd2
   } csr_index_type;

   // per-pixel classification handed from front to back
   typedef struct packed {
      logic band_first;
      logic emit;
      logic frame_done;
   } bad_flags_type;

endpackage

FILE: hw/rtl/bad_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the front end for size and step set-up.
module bad_div #(
   parameter int DIVD_W = 21,
   parameter int DIVS_W = 13
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DIVD_W-1:0] dividend,
   input  logic [DIVS_W-1:0] divisor,
   output logic              done,
   output logic [DIVD_W-1:0] quotient,
   output logic [DIVS_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIVD_W + 1);

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DIVD_W-1:0] quo_ff;
   logic [DIVS_W-1:0] rem_ff;
   logic [DIVS_W-1:0] dvs_ff;
   logic [DIVS_W:0]   shifted;
   logic              fits;
   logic [DIVS_W:0]   diff;

   // trial subtract of the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVD_W-1]};
      fits    = (shifted >= {1'b0, dvs_ff});
      diff    = shifted - {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start && !busy_ff) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVD_W);
            quo_ff  <= dividend;
            rem_ff  <= '0;
            dvs_ff  <= divisor;
         end else if (busy_ff) begin
            rem_ff <= fits ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
            quo_ff <= {quo_ff[DIVD_W-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

FILE: hw/rtl/bad_fifo.sv
// Short word queue between the classifying front end and the accumulator back end.
// Depends on bad_pkg for its depth.
module bad_fifo #(
   parameter int WIDTH = 51
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = bad_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff;
   logic [PTR_W-1:0] rd_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             do_push;
   logic             do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = slot_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // store the word
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   // advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         unique case ({do_push, do_pop})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

endmodule

FILE: hw/rtl/bad_front.sv
// Front end: configuration, target size set-up and per-pixel box classification.
// Depends on bad_pkg and bad_div.
module bad_front #(
   parameter int MAX_OUT_SIDE    = 256,
   parameter int MAX_SOURCE_SIDE = 4096,
   parameter int SRC_W           = 13,
   parameter int TGT_W           = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [bad_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bad_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bad_pkg::PIX_W-1:0]           req_tdata,
   output logic                                q_push,
   input  logic                                q_full,
   output logic [TGT_W-1:0]                    q_col,
   output logic [TGT_W-1:0]                    q_row,
   output bad_pkg::bad_flags_type              q_flags,
   output logic [bad_pkg::PIX_W-1:0]           q_pixel
);

   localparam int PROD_W = SRC_W + TGT_W;

   typedef enum logic [2:0] {
      F_CLAMP, F_SCALE, F_DIV_TW, F_DIV_TH, F_PREP_QX, F_DIV_QX, F_DIV_QY, F_RUN
   } fstate_type;

   fstate_type state_ff;

   logic [bad_pkg::CFG_SIDE_W-1:0] cfg_w_ff;
   logic [bad_pkg::CFG_SIDE_W-1:0] cfg_h_ff;
   logic [bad_pkg::CFG_MAX_W-1:0]  cfg_m_ff;
   logic [SRC_W-1:0] eff_w_ff, eff_h_ff;
   logic [TGT_W-1:0] m_ff, tw_ff, th_ff;
   logic [SRC_W-1:0] qx_ff, qy_ff;
   logic [TGT_W-1:0] rx_ff, ry_ff;
   logic [SRC_W-1:0] src_col_ff, src_row_ff;
   logic [TGT_W-1:0] out_col_ff, out_row_ff;
   logic [SRC_W-1:0] col_end_ff, row_end_ff, row_start_ff;
   logic [TGT_W-1:0] col_rem_ff, row_rem_ff;

   logic              div_clear;
   logic              div_start;
   logic [PROD_W-1:0] div_dividend;
   logic [SRC_W-1:0]  div_divisor;
   logic              div_done;
   logic [PROD_W-1:0] div_quo;
   logic [SRC_W-1:0]  div_rem;

   logic [SRC_W-1:0] big;
   logic             shrink;
   logic [TGT_W-1:0] div_q_min1;
   logic             accept;
   logic [SRC_W-1:0] col_inc, row_inc;
   logic             col_last, row_last, emit;
   logic [TGT_W:0]   col_rsum, row_rsum;
   logic             col_wrap, row_wrap;
   logic             csr_hit;

   function automatic logic [SRC_W-1:0] clamp_side(input logic [bad_pkg::CFG_SIDE_W-1:0] v);
      logic [SRC_W-1:0] r;
      if (v == '0) begin
         r = SRC_W'(1);
      end else if (32'(v) > 32'(MAX_SOURCE_SIDE)) begin
         r = SRC_W'(MAX_SOURCE_SIDE);
      end else begin
         r = SRC_W'(v);
      end
      return r;
   endfunction

   function automatic logic [TGT_W-1:0] clamp_max(input logic [bad_pkg::CFG_MAX_W-1:0] v);
      logic [TGT_W-1:0] r;
      if (v == '0) begin
         r = TGT_W'(1);
      end else if (32'(v) > 32'(MAX_OUT_SIDE)) begin
         r = TGT_W'(MAX_OUT_SIDE);
      end else begin
         r = TGT_W'(v);
      end
      return r;
   endfunction

   // abandon any set-up division in progress when a register is written
   assign div_clear = reset || csr_hit;

   bad_div #(
      .DIVD_W (PROD_W),
      .DIVS_W (SRC_W)
   ) u_div (
      .clock     (clock),
      .reset     (div_clear),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // set-up divisions, one after another
   always_comb begin
      big          = (eff_w_ff > eff_h_ff) ? eff_w_ff : eff_h_ff;
      shrink       = (32'(big) > 32'(m_ff));
      div_q_min1   = (div_quo == '0) ? TGT_W'(1) : TGT_W'(div_quo);
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = SRC_W'(1);
      unique case (state_ff)
         F_SCALE: begin
            div_start    = shrink;
            div_dividend = PROD_W'(eff_w_ff) * PROD_W'(m_ff);
            div_divisor  = big;
         end
         F_DIV_TW: begin
            div_start    = div_done;
            div_dividend = PROD_W'(eff_h_ff) * PROD_W'(m_ff);
            div_divisor  = big;
         end
         F_PREP_QX: begin
            div_start    = 1'b1;
            div_dividend = PROD_W'(eff_w_ff);
            div_divisor  = SRC_W'(tw_ff);
         end
         F_DIV_QX: begin
            div_start    = div_done;
            div_dividend = PROD_W'(eff_h_ff);
            div_divisor  = SRC_W'(th_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // classify the incoming pixel against the current box
   always_comb begin
      accept   = req_tvalid && req_tready;
      col_inc  = src_col_ff + 1'b1;
      row_inc  = src_row_ff + 1'b1;
      col_last = (col_inc == col_end_ff);
      row_last = (row_inc == row_end_ff);
      emit     = col_last && row_last;
      col_rsum = {1'b0, col_rem_ff} + {1'b0, rx_ff};
      row_rsum = {1'b0, row_rem_ff} + {1'b0, ry_ff};
      col_wrap = (col_rsum >= {1'b0, tw_ff});
      row_wrap = (row_rsum >= {1'b0, th_ff});
      csr_hit  = csr_we && ((csr_index == bad_pkg::CSR_SOURCE_WIDTH)
                         || (csr_index == bad_pkg::CSR_SOURCE_HEIGHT)
                         || (csr_index == bad_pkg::CSR_MAX_SIDE));
   end

   assign req_tready         = (state_ff == F_RUN) && !q_full;
   assign q_push             = accept;
   assign q_col              = out_col_ff;
   assign q_row              = out_row_ff;
   assign q_pixel            = req_tdata;
   assign q_flags.band_first = (src_row_ff == row_start_ff);
   assign q_flags.emit       = emit;
   assign q_flags.frame_done = emit && (out_col_ff + 1'b1 == tw_ff)
                                    && (out_row_ff + 1'b1 == th_ff);

   // hold configuration, run set-up, advance position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff <= bad_pkg::RST_SOURCE_SIDE;
         cfg_h_ff <= bad_pkg::RST_SOURCE_SIDE;
         cfg_m_ff <= bad_pkg::RST_MAX_SIDE;
         state_ff <= F_CLAMP;
      end else if (csr_hit) begin
         unique case (csr_index)
            bad_pkg::CSR_SOURCE_WIDTH:  cfg_w_ff <= csr_wdata;
            bad_pkg::CSR_SOURCE_HEIGHT: cfg_h_ff <= csr_wdata;
            default:                    cfg_m_ff <= bad_pkg::CFG_MAX_W'(csr_wdata);
         endcase
         state_ff <= F_CLAMP;
      end else begin
         unique case (state_ff)
            F_CLAMP: begin
               eff_w_ff <= clamp_side(cfg_w_ff);
               eff_h_ff <= clamp_side(cfg_h_ff);
               m_ff     <= clamp_max(cfg_m_ff);
               state_ff <= F_SCALE;
            end
            F_SCALE: begin
               if (shrink) begin
                  state_ff <= F_DIV_TW;
               end else begin
                  tw_ff    <= TGT_W'(eff_w_ff);
                  th_ff    <= TGT_W'(eff_h_ff);
                  state_ff <= F_PREP_QX;
               end
            end
            F_DIV_TW: begin
               if (div_done) begin
                  tw_ff    <= div_q_min1;
                  state_ff <= F_DIV_TH;
               end
            end
            F_DIV_TH: begin
               if (div_done) begin
                  th_ff    <= div_q_min1;
                  state_ff <= F_PREP_QX;
               end
            end
            F_PREP_QX: begin
               state_ff <= F_DIV_QX;
            end
            F_DIV_QX: begin
               if (div_done) begin
                  qx_ff    <= SRC_W'(div_quo);
                  rx_ff    <= TGT_W'(div_rem);
                  state_ff <= F_DIV_QY;
               end
            end
            F_DIV_QY: begin
               if (div_done) begin
                  qy_ff        <= SRC_W'(div_quo);
                  ry_ff        <= TGT_W'(div_rem);
                  src_col_ff   <= '0;
                  src_row_ff   <= '0;
                  out_col_ff   <= '0;
                  out_row_ff   <= '0;
                  col_end_ff   <= qx_ff;
                  col_rem_ff   <= rx_ff;
                  row_start_ff <= '0;
                  row_end_ff   <= SRC_W'(div_quo);
                  row_rem_ff   <= TGT_W'(div_rem);
                  state_ff     <= F_RUN;
               end
            end
            default: begin
               if (accept) begin
                  if (col_inc >= eff_w_ff) begin
                     // end of source row: restart columns
                     src_col_ff <= '0;
                     out_col_ff <= '0;
                     col_end_ff <= qx_ff;
                     col_rem_ff <= rx_ff;
                     if (row_inc >= eff_h_ff) begin
                        src_row_ff   <= '0;
                        out_row_ff   <= '0;
                        row_start_ff <= '0;
                        row_end_ff   <= qy_ff;
                        row_rem_ff   <= ry_ff;
                     end else begin
                        src_row_ff <= row_inc;
                        if (row_last) begin
                           out_row_ff   <= out_row_ff + 1'b1;
                           row_start_ff <= row_end_ff;
                           if (row_wrap) begin
                              row_end_ff <= row_end_ff + qy_ff + 1'b1;
                              row_rem_ff <= TGT_W'(row_rsum - {1'b0, th_ff});
                           end else begin
                              row_end_ff <= row_end_ff + qy_ff;
                              row_rem_ff <= TGT_W'(row_rsum);
                           end
                        end
                     end
                  end else begin
                     src_col_ff <= col_inc;
                     if (col_last) begin
                        out_col_ff <= out_col_ff + 1'b1;
                        if (col_wrap) begin
                           col_end_ff <= col_end_ff + qx_ff + 1'b1;
                           col_rem_ff <= TGT_W'(col_rsum - {1'b0, tw_ff});
                        end else begin
                           col_end_ff <= col_end_ff + qx_ff;
                           col_rem_ff <= TGT_W'(col_rsum);
                        end
                     end
                  end
               end
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/bad_back.sv
// Back end: per-column accumulator memory, averaging divider and result register.
// Depends on bad_pkg.
module bad_back #(
   parameter int MAX_OUT_SIDE = 256,
   parameter int TGT_W        = 9,
   parameter int SUM_W        = 32,
   parameter int CNT_W        = 25
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                q_valid,
   output logic                                q_pop,
   input  logic [TGT_W-1:0]                    q_col,
   input  logic [TGT_W-1:0]                    q_row,
   input  bad_pkg::bad_flags_type              q_flags,
   input  logic [bad_pkg::PIX_W-1:0]           q_pixel,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bad_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int NCH    = bad_pkg::NUM_CH;
   localparam int CHW    = bad_pkg::CH_W;
   localparam int ADDR_W = (MAX_OUT_SIDE > 1) ? $clog2(MAX_OUT_SIDE) : 1;
   localparam int MEM_W  = NCH * SUM_W + CNT_W;
   localparam int DV_W   = SUM_W + 1;

   typedef enum logic [1:0] {B_IDLE, B_RMW, B_DIV, B_OUT} bstate_type;

   bstate_type state_ff;

   logic [MEM_W-1:0]              acc_mem_ff [MAX_OUT_SIDE];
   logic [MEM_W-1:0]              rd_ff;
   logic [ADDR_W-1:0]             addr_ff;
   logic [TGT_W-1:0]              col_ff, row_ff;
   bad_pkg::bad_flags_type        flags_ff;
   logic [bad_pkg::PIX_W-1:0]     pix_ff;
   logic [SUM_W-1:0]              rem_ff [NCH];
   logic [bad_pkg::QUO_W-1:0]     quo_ff [NCH];
   logic [CNT_W-1:0]              cnt_ff;
   logic [bad_pkg::QUO_IDX_W-1:0] bit_ff;
   logic                          rsp_valid_ff;
   logic [bad_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                          rsp_last_ff;

   logic [MEM_W-1:0] new_word;
   logic [DV_W-1:0]  dv;
   logic             load_out;

   // fresh or accumulated box totals
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         if (flags_ff.band_first) begin
            new_word[c*SUM_W +: SUM_W] = SUM_W'(pix_ff[c*CHW +: CHW]);
         end else begin
            new_word[c*SUM_W +: SUM_W] = rd_ff[c*SUM_W +: SUM_W]
                                       + SUM_W'(pix_ff[c*CHW +: CHW]);
         end
      end
      new_word[NCH*SUM_W +: CNT_W] = flags_ff.band_first ? CNT_W'(1)
                                   : rd_ff[NCH*SUM_W +: CNT_W] + 1'b1;
      dv       = DV_W'(cnt_ff) << bit_ff;
      load_out = (state_ff == B_OUT) && (!rsp_valid_ff || rsp_tready);
   end

   assign q_pop = (state_ff == B_IDLE) && q_valid;

   // read-modify-write of the column accumulators
   always_ff @(posedge clock) begin
      if (q_pop) begin
         rd_ff <= acc_mem_ff[q_col[ADDR_W-1:0]];
      end
      if (state_ff == B_RMW) begin
         acc_mem_ff[addr_ff] <= new_word;
      end
   end

   // sequence one word: fetch and update, then divide and deliver for a box-completing word
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               if (q_valid) begin
                  addr_ff  <= q_col[ADDR_W-1:0];
                  col_ff   <= q_col;
                  row_ff   <= q_row;
                  flags_ff <= q_flags;
                  pix_ff   <= q_pixel;
                  state_ff <= B_RMW;
               end
            end
            B_RMW: begin
               if (flags_ff.emit) begin
                  for (int c = 0; c < NCH; c++) begin
                     rem_ff[c] <= new_word[c*SUM_W +: SUM_W];
                     quo_ff[c] <= '0;
                  end
                  cnt_ff   <= new_word[NCH*SUM_W +: CNT_W];
                  bit_ff   <= '1;
                  state_ff <= B_DIV;
               end else begin
                  state_ff <= B_IDLE;
               end
            end
            B_DIV: begin
               // one quotient bit per lane per cycle, most significant first
               for (int c = 0; c < NCH; c++) begin
                  if (DV_W'(rem_ff[c]) >= dv) begin
                     rem_ff[c]         <= SUM_W'(DV_W'(rem_ff[c]) - dv);
                     quo_ff[c][bit_ff] <= 1'b1;
                  end
               end
               bit_ff <= bit_ff - 1'b1;
               if (bit_ff == '0) begin
                  state_ff <= B_OUT;
               end
            end
            default: begin
               if (load_out) begin
                  state_ff <= B_IDLE;
               end
            end
         endcase
      end
   end

   // result register towards the receiver
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_out) begin
         rsp_data_ff <= {bad_pkg::COORD_W'(row_ff), bad_pkg::COORD_W'(col_ff),
                         quo_ff[3], quo_ff[2], quo_ff[1], quo_ff[0]};
         rsp_last_ff <= flags_ff.frame_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hw/rtl/box_average_image_downscale_unit.sv
// Box-average RGBA8 image downscaler, top level.
// Depends on bad_pkg, bad_front, bad_fifo and bad_back.
//
// Usage: write source_width, source_height and max_side on the csr_ port
// (index 0, 1, 2) while the block is idle; any valid write restarts the
// frame. Source pixels enter on req_ in raster order; one averaged output
// pixel leaves on rsp_ each time the last source pixel of an output box
// has been taken, with rsp_tlast marking the last output pixel of a frame.
// After reset or a write, req_tready stays low while the front end runs
// its set-up divisions on a 22-bit dividend: two after the last write, or
// four when the image is scaled down. A pixel is classified as it is taken
// and queued (four words deep); the back end takes one word at a time and
// does a read-modify-write of the column accumulator memory for it, and
// for a box-completing word then runs the averaging divider over the 8
// quotient bits and loads the result register. A stalled receiver holds
// the result register; the queue keeps accepting until full, then
// req_tready drops.
// Reset clears control state; accumulators are rebuilt on each band's first row.
module box_average_image_downscale_unit #(
   parameter int MAX_OUT_SIDE    = 256,
   parameter int MAX_SOURCE_SIDE = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [bad_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bad_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
   input  logic [bad_pkg::PIX_W-1:0]          req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // red_out, green_out, blue_out, alpha_out, dest_col, dest_row (8 bits each)
   output logic [bad_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // frame_done
   output logic                               rsp_tlast
);

   localparam int SRC_W  = $clog2(MAX_SOURCE_SIDE + 1);
   localparam int TGT_W  = $clog2(MAX_OUT_SIDE + 1);
   localparam int LOG_S  = $clog2(MAX_SOURCE_SIDE);
   localparam int SUM_W  = 2 * LOG_S + bad_pkg::CH_W;
   localparam int CNT_W  = 2 * LOG_S + 1;
   localparam int FLG_W  = $bits(bad_pkg::bad_flags_type);
   localparam int ENTRY_W = bad_pkg::PIX_W + FLG_W + 2 * TGT_W;

   logic                          f_push;
   logic                          f_full;
   logic [TGT_W-1:0]              f_col, f_row;
   bad_pkg::bad_flags_type        f_flags;
   logic [bad_pkg::PIX_W-1:0]     f_pixel;
   logic [ENTRY_W-1:0]            push_word;
   logic [ENTRY_W-1:0]            pop_word;
   logic                          b_valid;
   logic                          b_pop;

   bad_front #(
      .MAX_OUT_SIDE    (MAX_OUT_SIDE),
      .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE),
      .SRC_W           (SRC_W),
      .TGT_W           (TGT_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_push     (f_push),
      .q_full     (f_full),
      .q_col      (f_col),
      .q_row      (f_row),
      .q_flags    (f_flags),
      .q_pixel    (f_pixel)
   );

   assign push_word = {f_pixel, f_flags, f_row, f_col};

   bad_fifo #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data (push_word),
      .full      (f_full),
      .pop       (b_pop),
      .valid     (b_valid),
      .pop_data  (pop_word)
   );

   bad_back #(
      .MAX_OUT_SIDE (MAX_OUT_SIDE),
      .TGT_W        (TGT_W),
      .SUM_W        (SUM_W),
      .CNT_W        (CNT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (b_valid),
      .q_pop      (b_pop),
      .q_col      (pop_word[TGT_W-1:0]),
      .q_row      (pop_word[2*TGT_W-1:TGT_W]),
      .q_flags    (bad_pkg::bad_flags_type'(pop_word[2*TGT_W +: FLG_W])),
      .q_pixel    (pop_word[ENTRY_W-1 -: bad_pkg::PIX_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: tb/box_average_image_downscale_unit_checker.sv
// Checker for the box-average downscaler: watches the pixel, result and
// register ports, predicts each averaged output word and compares it.
// Depends on bad_pkg only.
module box_average_image_downscale_unit_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [bad_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bad_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [bad_pkg::PIX_W-1:0]        req_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [bad_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             rsp_tlast,
   output int                               error_count,
   output int                               pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OUT_MAX = 256;
   localparam int SRC_MAX = 4096;
   localparam int NCH     = bad_pkg::NUM_CH;
   localparam int CHW     = bad_pkg::CH_W;
   localparam int PXW     = bad_pkg::PIX_W;
   localparam int CDW     = bad_pkg::COORD_W;

   typedef struct packed {
      logic                           frame_done;
      logic [bad_pkg::RSP_DATA_W-1:0] data;
   } out_pixel_type;

   // register copies
   int unsigned reg_width, reg_height, reg_max_side;
   // frame geometry and position
   int unsigned eff_width, eff_height, tgt_width, tgt_height;
   int unsigned col, row, out_col, out_row, box_col_end, band_row_end;
   longint unsigned acc_sum [OUT_MAX][NCH];
   int unsigned     acc_count [OUT_MAX];
   out_pixel_type   expected_pixels [$];

   function automatic int unsigned clamp_side(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned box_start(int unsigned idx, int unsigned n,
                                             int unsigned t);
      return 32'((longint'(idx) * n) / t);
   endfunction

   function automatic int unsigned box_end(int unsigned idx, int unsigned n,
                                           int unsigned t);
      int unsigned s, e;
      s = box_start(idx, n, t);
      e = 32'((longint'(idx + 1) * n) / t);
      return (e > s) ? e : s + 1;
   endfunction

   task automatic restart_geometry();
      int unsigned m, big;
      m = clamp_side(reg_max_side, OUT_MAX);
      eff_width = clamp_side(reg_width, SRC_MAX);
      eff_height = clamp_side(reg_height, SRC_MAX);
      big = (eff_width > eff_height) ? eff_width : eff_height;
      if (big > m) begin
         tgt_width = (eff_width * m) / big;
         tgt_height = (eff_height * m) / big;
         if (tgt_width < 1) tgt_width = 1;
         if (tgt_height < 1) tgt_height = 1;
      end else begin
         tgt_width = eff_width;
         tgt_height = eff_height;
      end
      col = 0; row = 0; out_col = 0; out_row = 0;
      box_col_end = box_end(0, eff_width, tgt_width);
      band_row_end = box_end(0, eff_height, tgt_height);
   endtask

   task automatic take_pixel(logic [PXW-1:0] pix);
      int unsigned x, n;
      logic first_row, col_last, row_last;
      out_pixel_type o;
      x = out_col % OUT_MAX;
      first_row = (row == box_start(out_row, eff_height, tgt_height));
      col_last = (col + 1 == box_col_end);
      row_last = (row + 1 == band_row_end);
      // overwrite on a band's first row, accumulate otherwise
      for (int c = 0; c < NCH; c++) begin
         if (first_row) acc_sum[x][c] = pix[c*CHW +: CHW];
         else acc_sum[x][c] += pix[c*CHW +: CHW];
      end
      acc_count[x] = first_row ? 1 : acc_count[x] + 1;
      if (col_last && row_last) begin
         n = (acc_count[x] != 0) ? acc_count[x] : 1;
         for (int c = 0; c < NCH; c++)
            o.data[c*CHW +: CHW] = 8'(acc_sum[x][c] / n);
         o.data[PXW +: CDW] = 8'(out_col);
         o.data[PXW+CDW +: CDW] = 8'(out_row);
         o.frame_done = (out_col + 1 == tgt_width) && (out_row + 1 == tgt_height);
         expected_pixels.insert(expected_pixels.size(), o);
      end
      // advance position, wrapping at row and frame ends
      if (col + 1 >= eff_width) begin
         col = 0; out_col = 0;
         box_col_end = box_end(0, eff_width, tgt_width);
         if (row + 1 >= eff_height) begin
            row = 0; out_row = 0;
         end else begin
            if (row_last) out_row++;
            row++;
         end
         band_row_end = box_end(out_row, eff_height, tgt_height);
      end else begin
         if (col_last) begin
            out_col++;
            box_col_end = box_end(out_col, eff_width, tgt_width);
         end
         col++;
      end
   endtask

   task automatic compare_pixel(logic [bad_pkg::RSP_DATA_W-1:0] d, logic last);
      out_pixel_type e;
      string names [6] = '{"red_out", "green_out", "blue_out", "alpha_out",
                           "dest_col", "dest_row"};
      if (expected_pixels.size() == 0) begin
         $error("unexpected output word %h", d);
         error_count++;
         return;
      end
      e = expected_pixels.pop_front();
      for (int f = 0; f < 6; f++)
         if (d[f*8 +: 8] !== e.data[f*8 +: 8]) begin
            $error("%s: expected %0d, got %0d", names[f], e.data[f*8 +: 8], d[f*8 +: 8]);
            error_count++;
         end
      if (last !== e.frame_done) begin
         $error("frame_done: expected %0d, got %0d", e.frame_done, last);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reg_width = 1; reg_height = 1; reg_max_side = 256;
         error_count = 0;
         expected_pixels.delete();
         restart_geometry();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_pixel(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) take_pixel(req_tdata);
         if (csr_we) begin
            unique case (csr_index)
               bad_pkg::CSR_SOURCE_WIDTH:  reg_width = csr_wdata;
               bad_pkg::CSR_SOURCE_HEIGHT: reg_height = csr_wdata;
               bad_pkg::CSR_MAX_SIDE:      reg_max_side = csr_wdata[bad_pkg::CFG_MAX_W-1:0];
               default:                    ;
            endcase
            if (csr_index inside {bad_pkg::CSR_SOURCE_WIDTH, bad_pkg::CSR_SOURCE_HEIGHT,
                                  bad_pkg::CSR_MAX_SIDE})
               restart_geometry();
         end
      end
      pending_count = expected_pixels.size();
   end
endmodule

FILE: tb/box_average_image_downscale_unit_tb.sv
// Testbench top for the box-average downscaler: clock, reset, register
// writes, pixel stimulus and receiver stalls; verdict from the checker.
// Depends on bad_pkg, box_average_image_downscale_unit and its checker.
module box_average_image_downscale_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [bad_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [bad_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bad_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [bad_pkg::PIX_W-1:0]      req_tdata = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [bad_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   int                             error_count, pending_count;
   int                             pixels_sent = 0;
   int                             hold_requests = 0;
   int                             holds_served = 0;
   bit                             quiet_tail = 1'b0;

   always #6 clock = ~clock;

   box_average_image_downscale_unit i_dut (.*);

   box_average_image_downscale_unit_checker i_checker (.*);

   // write one register at a falling edge
   task automatic write_reg(bad_pkg::csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bad_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_geometry(int unsigned w, int unsigned h, int unsigned m);
      write_reg(bad_pkg::CSR_SOURCE_WIDTH, w);
      write_reg(bad_pkg::CSR_SOURCE_HEIGHT, h);
      write_reg(bad_pkg::CSR_MAX_SIDE, m);
   endtask

   // offer one pixel and hold it until taken; random gaps before it
   task automatic send_pixel(logic [bad_pkg::PIX_W-1:0] pix);
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      pixels_sent++;
   endtask

   function automatic logic [bad_pkg::PIX_W-1:0] random_pixel();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // drop the offer and wait for the block to drain before a register write
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // send whole frames of random pixels
   task automatic send_frames(int unsigned w, int unsigned h, int unsigned m,
                              int unsigned frames);
      drain();
      set_geometry(w, h, m);
      repeat (frames * w * h) send_pixel(random_pixel());
   endtask

   // receiver: random stall bursts, a long hold-off on request
   always begin
      @(negedge clock);
      if (holds_served < hold_requests) begin
         rsp_tready <= 1'b0;
         repeat (300) @(negedge clock);
         holds_served++;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 12) - 1) @(negedge clock);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      #4_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int unsigned w, h, m;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: 1x1 default, extremes of the channels
      send_pixel('0);
      send_pixel('1);
      send_pixel(32'h8040_2010);
      // 4x2 down to max side 2: averaging boxes
      drain();
      set_geometry(4, 2, 2);
      for (int i = 0; i < 8; i++) send_pixel((i % 2) ? '1 : 32'h0101_0101 * i);
      // uneven boxes, unknown register index, out-of-range values
      drain();
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= CSR_UNUSED_INDEX; csr_wdata <= '1;
      @(negedge clock);
      csr_we <= 1'b0;
      set_geometry(0, 0, 0);
      send_pixel('1);
      send_pixel(32'h5555_AAAA);
      send_frames(3, 5, 2, 1);
      // long hold-off of the receiver while pixels keep coming
      drain();
      set_geometry(2, 2, 256);
      hold_requests++;
      repeat (24) send_pixel(random_pixel());
      // width above the source limit: part of one clamped row
      drain();
      set_geometry(8191, 1, 1);
      repeat (150) send_pixel(random_pixel());
      // uneven shrink along one side, max side above its limit
      send_frames(300, 1, 256, 1);
      send_frames(1, 300, 511, 1);
      // random geometries
      while (pixels_sent < 1500) begin
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 8);
         m = ($urandom_range(0, 1)) ? $urandom_range(1, 8) : 256;
         if (pixels_sent > 1350) quiet_tail = 1'b1;
         send_frames(w, h, m, $urandom_range(1, 2));
      end
      drain();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule
